// ----- hdl/cpbd_pkg.sv -----
// Shared package of the peak box decoder: register codes, reset values,
// datapath widths and the lane control struct. Depends on nothing.
package cpbd_pkg;

  // Heatmap cell size in network input pixels.
  localparam int STRIDE = 4;
  localparam int STRIDE_W = $clog2(STRIDE + 1);

  // Field widths.
  localparam int CELL_W = 10;
  localparam int HEAT_W = 16;
  localparam int FIX_W = 19;
  localparam int IMG_W = 13;
  localparam int NET_W = 12;
  localparam int INV_W = 24;
  localparam int CFG_W = 24;

  // Datapath widths: v = (cell*256 + offset +/- dist)*STRIDE - net*128,
  // product v*inverse_scale, rounded edge is the product shifted down 24 bits.
  localparam int A_W = 21;
  localparam int V_W = A_W + STRIDE_W + 1;
  localparam int PROD_W = V_W + INV_W + 1;
  localparam int P_W = PROD_W + 1;
  localparam int FRAC_W = 24;
  localparam int E_W = P_W - FRAC_W;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH       = 3'd0,
    REG_MAP_HEIGHT      = 3'd1,
    REG_SCORE_THRESHOLD = 3'd2,
    REG_IMAGE_WIDTH     = 3'd3,
    REG_IMAGE_HEIGHT    = 3'd4,
    REG_NET_WIDTH       = 3'd5,
    REG_NET_HEIGHT      = 3'd6,
    REG_INVERSE_SCALE   = 3'd7
  } cpbd_reg_t;

  localparam logic [CELL_W-1:0] RST_MAP_WIDTH = 10'd272;
  localparam logic [CELL_W-1:0] RST_MAP_HEIGHT = 10'd152;
  localparam logic [HEAT_W-1:0] RST_SCORE_THRESHOLD = 16'd26214;
  localparam logic [IMG_W-1:0] RST_IMAGE_WIDTH = 13'd1920;
  localparam logic [IMG_W-1:0] RST_IMAGE_HEIGHT = 13'd1080;
  localparam logic [NET_W-1:0] RST_NET_WIDTH = 12'd1088;
  localparam logic [NET_W-1:0] RST_NET_HEIGHT = 12'd608;
  localparam logic [INV_W-1:0] RST_INVERSE_SCALE = 24'd115652;

  // Load enables of the three pipeline stages inside an edge lane.
  typedef struct packed {
    logic load_v;
    logic load_p;
    logic load_e;
  } cpbd_lane_ctl_t;

endpackage

// ----- hdl/cpbd_edge_lane.sv -----
// One box edge lane: maps a cell coordinate plus offset and distance to a
// rounded image pixel in three registered stages. Depends on cpbd_pkg.
module cpbd_edge_lane (
  input  logic                                   clk,
  input  cpbd_pkg::cpbd_lane_ctl_t               ctl,
  input  logic [cpbd_pkg::CELL_W-1:0]            coord,
  input  logic signed [cpbd_pkg::FIX_W-1:0]      offset,
  input  logic signed [cpbd_pkg::FIX_W-1:0]      span,
  input  logic                                   dist_neg,
  input  logic                                   end_edge,
  input  logic [cpbd_pkg::NET_W-1:0]             net_size,
  input  logic [cpbd_pkg::IMG_W-1:0]             image_size,
  input  logic [cpbd_pkg::INV_W-1:0]             inverse_scale,
  output logic signed [cpbd_pkg::E_W-1:0]        edge_pos
);

  localparam int V_W = cpbd_pkg::V_W;
  localparam int P_W = cpbd_pkg::P_W;
  localparam int PROD_W = cpbd_pkg::PROD_W;
  localparam int E_W = cpbd_pkg::E_W;
  localparam int FRAC_W = cpbd_pkg::FRAC_W;
  localparam logic signed [V_W-1:0] STRIDE_S = V_W'(cpbd_pkg::STRIDE);
  localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(64'd1 << (FRAC_W - 1));

  logic signed [V_W-1:0]    cell_s, off_s, dist_s, net_s, a_val, v_next;
  logic signed [V_W-1:0]    v;
  logic signed [PROD_W-1:0] prod;
  logic signed [P_W-1:0]    p_val;
  logic signed [E_W-1:0]    e_next;

  // Stage one: position in Q.8 cells, scaled to network pixels and centered.
  always_comb begin
    cell_s = $signed(V_W'({coord, 8'b0}));
    off_s  = V_W'(offset);
    dist_s = V_W'(span);
    net_s  = $signed(V_W'({net_size, 7'b0}));
    if (dist_neg) begin
      a_val = cell_s + off_s - dist_s;
    end else begin
      a_val = cell_s + off_s + dist_s;
    end
    v_next = a_val * STRIDE_S - net_s;
  end

  // Stage three: recenter in the image and round half toward plus infinity.
  always_comb begin
    p_val = P_W'(prod) + $signed(P_W'({image_size, 23'b0})) + ROUND_HALF;
    e_next = $signed(p_val[P_W-1:FRAC_W]) + $signed(E_W'(end_edge));
  end

  always_ff @(posedge clk) begin
    if (ctl.load_v) begin
      v <= v_next;
    end
    if (ctl.load_p) begin
      prod <= PROD_W'(v) * PROD_W'($signed({1'b0, inverse_scale}));
    end
    if (ctl.load_e) begin
      edge_pos <= e_next;
    end
  end

endmodule

// ----- hdl/centernet_peak_box_decode.sv -----
// Top level of the heatmap peak box decoder: config registers, cell counter,
// pipeline control, clipping and the output register. Depends on cpbd_pkg
// and cpbd_edge_lane.
//
// Usage: the input channel carries one heatmap cell per transaction, in raster
// order. A cell is accepted at a rising edge with in_valid high and in_stall
// low. The internal column and row counters tag each cell and wrap at the
// configured map size. A cell whose heat equals its pooled heat and whose
// pooled heat is above the threshold is mapped to a pixel box, clipped to the
// image and, if it is not empty, sent out as one transaction on the output
// channel (out_valid, out_stall). Other cells produce nothing.
// The block takes one cell per cycle while in_stall is low. The accepting edge
// loads the input register; a box then passes through the centering add, the
// multiplier, the rounding add and finally the clip stage that loads the
// output register, each a registered stage.
// The box edges are computed by four lanes in parallel, each with one
// 25 by 25 bit multiplier. When the receiver stalls, the pipeline keeps
// moving until its stages are full and only then raises in_stall, so bubbles
// and dropped cells are squeezed out. Synchronous reset empties the pipeline,
// clears the counters and loads the default configuration. Configuration is
// written through cfg_valid/cfg_ready (always ready) and must only change
// while no cell is in flight.
module centernet_peak_box_decode (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [cpbd_pkg::CFG_W-1:0]          cfg_data,
  // Cell input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cpbd_pkg::HEAT_W-1:0]         heat,
  input  logic [cpbd_pkg::HEAT_W-1:0]         pooled_heat,
  input  logic signed [cpbd_pkg::FIX_W-1:0]   offset_x,
  input  logic signed [cpbd_pkg::FIX_W-1:0]   offset_y,
  input  logic signed [cpbd_pkg::FIX_W-1:0]   dist_left,
  input  logic signed [cpbd_pkg::FIX_W-1:0]   dist_top,
  input  logic signed [cpbd_pkg::FIX_W-1:0]   dist_right,
  input  logic signed [cpbd_pkg::FIX_W-1:0]   dist_bottom,
  // Box output channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cpbd_pkg::CELL_W-1:0]         cell_col,
  output logic [cpbd_pkg::CELL_W-1:0]         cell_row,
  output logic [cpbd_pkg::IMG_W-1:0]          box_left,
  output logic [cpbd_pkg::IMG_W-1:0]          box_top,
  output logic [cpbd_pkg::IMG_W-1:0]          box_right,
  output logic [cpbd_pkg::IMG_W-1:0]          box_bottom,
  output logic [cpbd_pkg::HEAT_W-1:0]         score
);

  localparam int CELL_W = cpbd_pkg::CELL_W;
  localparam int HEAT_W = cpbd_pkg::HEAT_W;
  localparam int FIX_W = cpbd_pkg::FIX_W;
  localparam int IMG_W = cpbd_pkg::IMG_W;
  localparam int E_W = cpbd_pkg::E_W;

  typedef struct packed {
    logic                  ok;
    logic [IMG_W-1:0]      first;
    logic [IMG_W-1:0]      last;
  } axis_t;

  // Orders both edges of one axis, clips them to [0, size) and reports
  // whether anything is left. The end edge is exclusive on entry.
  function automatic axis_t clip_axis(input logic signed [E_W-1:0] e0,
                                      input logic signed [E_W-1:0] e1,
                                      input logic [IMG_W-1:0] size);
    logic signed [E_W-1:0] lo, hi, size_s, last_s;
    axis_t res;
    size_s = $signed(E_W'(size));
    if (e1 < e0) begin
      lo = e1;
      hi = e0;
    end else begin
      lo = e0;
      hi = e1;
    end
    if (lo < 0) begin
      lo = '0;
    end
    if (hi > size_s) begin
      hi = size_s;
    end
    last_s = hi - E_W'(1);
    res.ok = hi > lo;
    res.first = lo[IMG_W-1:0];
    res.last = last_s[IMG_W-1:0];
    return res;
  endfunction

  // Configuration registers.
  logic [CELL_W-1:0]          map_width, map_height;
  logic [HEAT_W-1:0]          score_threshold;
  logic [IMG_W-1:0]           image_width, image_height;
  logic [cpbd_pkg::NET_W-1:0] net_width, net_height;
  logic [cpbd_pkg::INV_W-1:0] inverse_scale;

  // Cell position counters.
  logic [CELL_W-1:0] col_count, row_count;

  // Pipeline valid bits: a is the input register, b to d are lane stages.
  logic valid_a, valid_b, valid_c, valid_d;
  logic en_a, en_b, en_c, en_d, en_e;
  logic accept, peak_a;
  cpbd_pkg::cpbd_lane_ctl_t lane_ctl;

  // Input register.
  logic [HEAT_W-1:0]        heat_a, pooled_a;
  logic signed [FIX_W-1:0]  off_x_a, off_y_a, dl_a, dt_a, dr_a, db_a;
  logic [CELL_W-1:0]        col_a, row_a;

  // Side data that travels next to the lanes.
  logic [CELL_W-1:0] col_b, row_b, col_c, row_c, col_d, row_d;
  logic [HEAT_W-1:0] score_b, score_c, score_d;

  logic signed [E_W-1:0] edge_l, edge_t, edge_r, edge_b;
  axis_t x_axis, y_axis;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= cpbd_pkg::RST_MAP_WIDTH;
      map_height <= cpbd_pkg::RST_MAP_HEIGHT;
      score_threshold <= cpbd_pkg::RST_SCORE_THRESHOLD;
      image_width <= cpbd_pkg::RST_IMAGE_WIDTH;
      image_height <= cpbd_pkg::RST_IMAGE_HEIGHT;
      net_width <= cpbd_pkg::RST_NET_WIDTH;
      net_height <= cpbd_pkg::RST_NET_HEIGHT;
      inverse_scale <= cpbd_pkg::RST_INVERSE_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cpbd_pkg::cpbd_reg_t'(cfg_index))
        cpbd_pkg::REG_MAP_WIDTH:       map_width <= cfg_data[CELL_W-1:0];
        cpbd_pkg::REG_MAP_HEIGHT:      map_height <= cfg_data[CELL_W-1:0];
        cpbd_pkg::REG_SCORE_THRESHOLD: score_threshold <= cfg_data[HEAT_W-1:0];
        cpbd_pkg::REG_IMAGE_WIDTH:     image_width <= cfg_data[IMG_W-1:0];
        cpbd_pkg::REG_IMAGE_HEIGHT:    image_height <= cfg_data[IMG_W-1:0];
        cpbd_pkg::REG_NET_WIDTH:       net_width <= cfg_data[cpbd_pkg::NET_W-1:0];
        cpbd_pkg::REG_NET_HEIGHT:      net_height <= cfg_data[cpbd_pkg::NET_W-1:0];
        cpbd_pkg::REG_INVERSE_SCALE:   inverse_scale <= cfg_data[cpbd_pkg::INV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Each stage loads when it is empty or when the stage after it loads, so
  // the stall only reaches the input once every stage holds a cell.
  always_comb begin
    en_e = !out_valid || !out_stall;
    en_d = !valid_d || en_e;
    en_c = !valid_c || en_d;
    en_b = !valid_b || en_c;
    en_a = !valid_a || en_b;
    in_stall = !en_a;
    accept = in_valid && en_a;
    peak_a = (heat_a == pooled_a) && (pooled_a > score_threshold);
    lane_ctl.load_v = en_b;
    lane_ctl.load_p = en_c;
    lane_ctl.load_e = en_d;
  end

  // The counters step on every accepted cell, peak or not. The compare is one
  // bit wider so that a register lowered below the counter still wraps.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if ({1'b0, col_count} + 11'd1 >= {1'b0, map_width}) begin
        col_count <= '0;
        if ({1'b0, row_count} + 11'd1 >= {1'b0, map_height}) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + 10'd1;
        end
      end else begin
        col_count <= col_count + 10'd1;
      end
    end
  end

  // Valid bits. Non-peak cells are dropped on their way out of the input
  // register, empty boxes on their way into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) begin
        valid_a <= in_valid;
      end
      if (en_b) begin
        valid_b <= valid_a && peak_a;
      end
      if (en_c) begin
        valid_c <= valid_b;
      end
      if (en_d) begin
        valid_d <= valid_c;
      end
      if (en_e) begin
        out_valid <= valid_d && x_axis.ok && y_axis.ok;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en_a) begin
      heat_a <= heat;
      pooled_a <= pooled_heat;
      off_x_a <= offset_x;
      off_y_a <= offset_y;
      dl_a <= dist_left;
      dt_a <= dist_top;
      dr_a <= dist_right;
      db_a <= dist_bottom;
      col_a <= col_count;
      row_a <= row_count;
    end
    if (en_b) begin
      col_b <= col_a;
      row_b <= row_a;
      score_b <= pooled_a;
    end
    if (en_c) begin
      col_c <= col_b;
      row_c <= row_b;
      score_c <= score_b;
    end
    if (en_d) begin
      col_d <= col_c;
      row_d <= row_c;
      score_d <= score_c;
    end
    if (en_e) begin
      cell_col <= col_d;
      cell_row <= row_d;
      box_left <= x_axis.first;
      box_right <= x_axis.last;
      box_top <= y_axis.first;
      box_bottom <= y_axis.last;
      score <= score_d;
    end
  end

  // The edge lanes. Left and top subtract their distance; right and bottom
  // add it and come out one past the last pixel.
  cpbd_edge_lane u_lane_left (
    .clk(clk), .ctl(lane_ctl), .coord(col_a), .offset(off_x_a), .span(dl_a),
    .dist_neg(1'b1), .end_edge(1'b0), .net_size(net_width),
    .image_size(image_width), .inverse_scale(inverse_scale), .edge_pos(edge_l)
  );

  cpbd_edge_lane u_lane_right (
    .clk(clk), .ctl(lane_ctl), .coord(col_a), .offset(off_x_a), .span(dr_a),
    .dist_neg(1'b0), .end_edge(1'b1), .net_size(net_width),
    .image_size(image_width), .inverse_scale(inverse_scale), .edge_pos(edge_r)
  );

  cpbd_edge_lane u_lane_top (
    .clk(clk), .ctl(lane_ctl), .coord(row_a), .offset(off_y_a), .span(dt_a),
    .dist_neg(1'b1), .end_edge(1'b0), .net_size(net_height),
    .image_size(image_height), .inverse_scale(inverse_scale), .edge_pos(edge_t)
  );

  cpbd_edge_lane u_lane_bottom (
    .clk(clk), .ctl(lane_ctl), .coord(row_a), .offset(off_y_a), .span(db_a),
    .dist_neg(1'b0), .end_edge(1'b1), .net_size(net_height),
    .image_size(image_height), .inverse_scale(inverse_scale), .edge_pos(edge_b)
  );

  always_comb begin
    x_axis = clip_axis(edge_l, edge_r, image_width);
    y_axis = clip_axis(edge_t, edge_b, image_height);
  end

  // The input stalls only when every pipeline stage is occupied.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (valid_a && valid_b && valid_c && valid_d && out_valid))
    else $error("input stalled while the pipeline has an empty stage");

  // A delivered box is never inverted.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (box_left <= box_right && box_top <= box_bottom))
    else $error("box edges out of order");

  // The column counter either steps by one or wraps on an accepted cell.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (col_count == '0 || col_count == $past(col_count) + 10'd1))
    else $error("column counter skipped");

  // A new output transaction only comes from an occupied rounding stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(valid_d))
    else $error("output valid without a cell in the last lane stage");

endmodule

// ----- sim/tb_centernet_peak_box_decode.sv -----
// Self-checking testbench of the heatmap peak box decoder: directed and random cells
// under several register settings, checked against a cycle-free predictor of the boxes.
// Depends on cpbd_pkg and centernet_peak_box_decode.
module tb_centernet_peak_box_decode;

  localparam int HEAT_W = cpbd_pkg::HEAT_W;
  localparam int FIX_W = cpbd_pkg::FIX_W;
  localparam int CELL_W = cpbd_pkg::CELL_W;
  localparam int IMG_W = cpbd_pkg::IMG_W;
  localparam int NET_W = cpbd_pkg::NET_W;
  localparam int INV_W = cpbd_pkg::INV_W;
  localparam int CFG_W = cpbd_pkg::CFG_W;
  localparam int FRAC_W = cpbd_pkg::FRAC_W;
  localparam int STRIDE = cpbd_pkg::STRIDE;

  // Cycles to let pass after the last expected box, so that cells which
  // produce no box have left the five-stage pipeline before a register write.
  localparam int DRAIN_CYCLES = 8;
  // Upper bound on the wait for outstanding boxes at the end of a phase.
  localparam int SETTLE_LIMIT = 4000;
  localparam int MAX_WAIT = 18;
  localparam int MAX_REPORTS = 10;
  localparam longint HALF_PIXEL = 64'sd8388608;

  // One heatmap cell as it is driven on the input channel.
  typedef struct packed {
    logic [HEAT_W-1:0] heat;
    logic [HEAT_W-1:0] pooled;
    logic [FIX_W-1:0]  off_x;
    logic [FIX_W-1:0]  off_y;
    logic [FIX_W-1:0]  d_left;
    logic [FIX_W-1:0]  d_top;
    logic [FIX_W-1:0]  d_right;
    logic [FIX_W-1:0]  d_bottom;
  } cell_t;

  // One decoded box as it appears on the output channel.
  typedef struct packed {
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    logic [IMG_W-1:0]  left;
    logic [IMG_W-1:0]  top;
    logic [IMG_W-1:0]  right;
    logic [IMG_W-1:0]  bottom;
    logic [HEAT_W-1:0] score;
  } box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [2:0]           cfg_index = cpbd_pkg::REG_MAP_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [HEAT_W-1:0]    heat = '0;
  logic [HEAT_W-1:0]    pooled_heat = '0;
  logic [FIX_W-1:0]     offset_x = '0;
  logic [FIX_W-1:0]     offset_y = '0;
  logic [FIX_W-1:0]     dist_left = '0;
  logic [FIX_W-1:0]     dist_top = '0;
  logic [FIX_W-1:0]     dist_right = '0;
  logic [FIX_W-1:0]     dist_bottom = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CELL_W-1:0]    cell_col;
  logic [CELL_W-1:0]    cell_row;
  logic [IMG_W-1:0]     box_left;
  logic [IMG_W-1:0]     box_top;
  logic [IMG_W-1:0]     box_right;
  logic [IMG_W-1:0]     box_bottom;
  logic [HEAT_W-1:0]    score;

  centernet_peak_box_decode i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .heat        (heat),
    .pooled_heat (pooled_heat),
    .offset_x    (offset_x),
    .offset_y    (offset_y),
    .dist_left   (dist_left),
    .dist_top    (dist_top),
    .dist_right  (dist_right),
    .dist_bottom (dist_bottom),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_right   (box_right),
    .box_bottom  (box_bottom),
    .score       (score)
  );

  always #1 clk = ~clk;

  // Cells waiting to be driven, and boxes that the predictor says must come out.
  cell_t cell_queue[$];
  box_t  box_queue[$];

  // Predictor copy of the register file and of the raster position counter.
  longint map_cols  = cpbd_pkg::RST_MAP_WIDTH;
  longint map_rows  = cpbd_pkg::RST_MAP_HEIGHT;
  longint peak_floor = cpbd_pkg::RST_SCORE_THRESHOLD;
  longint img_w     = cpbd_pkg::RST_IMAGE_WIDTH;
  longint img_h     = cpbd_pkg::RST_IMAGE_HEIGHT;
  longint net_w     = cpbd_pkg::RST_NET_WIDTH;
  longint net_h     = cpbd_pkg::RST_NET_HEIGHT;
  longint inv_scale = cpbd_pkg::RST_INVERSE_SCALE;
  longint col_pos   = 0;
  longint row_pos   = 0;

  // Handshake bookkeeping shared between the clocked processes. The rising
  // edge process records what was accepted; the falling edge processes react.
  cell_t cur_cell;
  bit    cell_busy  = 1'b0;
  bit    cell_taken = 1'b0;
  int    cell_gap   = 0;
  int    box_stall  = 0;
  bit    idle_on    = 1'b1;

  int cells_accepted = 0;
  int boxes_checked  = 0;
  int mismatches     = 0;
  int failures       = 0;
  int settings_count = 0;

  // Number of cycles one side holds off before its next transaction. A phase
  // with idling switched off runs the channels back to back.
  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // Maps one box edge to image pixels. The offset and distance are in Q.8
  // cells; the product with the Q8.16 scale lands in Q.24, and the +half
  // followed by an arithmetic shift rounds half toward plus infinity.
  function automatic longint project_edge(longint coord, longint off, longint span,
                                          longint net, longint img);
    longint a;
    longint v;
    longint p;
    a = coord * 256 + off + span;
    v = a * STRIDE - net * 128;
    p = v * inv_scale + img * HALF_PIXEL + HALF_PIXEL;
    return p >>> FRAC_W;
  endfunction

  // Works out the box, if any, of one accepted cell and steps the raster
  // counter the way the block does.
  function automatic void predict_box(cell_t c);
    longint x0;
    longint x1;
    longint y0;
    longint y1;
    longint t;
    box_t   b;
    if (c.heat == c.pooled && longint'(c.pooled) > peak_floor) begin
      x0 = project_edge(col_pos, $signed(c.off_x), -longint'($signed(c.d_left)),
                        net_w, img_w);
      x1 = project_edge(col_pos, $signed(c.off_x), $signed(c.d_right), net_w, img_w) + 1;
      y0 = project_edge(row_pos, $signed(c.off_y), -longint'($signed(c.d_top)),
                        net_h, img_h);
      y1 = project_edge(row_pos, $signed(c.off_y), $signed(c.d_bottom), net_h, img_h) + 1;
      // Negative distances turn a box inside out; order the edges again.
      if (x1 < x0) begin
        t = x0;
        x0 = x1;
        x1 = t;
      end
      if (y1 < y0) begin
        t = y0;
        y0 = y1;
        y1 = t;
      end
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > img_w) x1 = img_w;
      if (y1 > img_h) y1 = img_h;
      // A box that is empty after clipping produces no transaction.
      if (x1 > x0 && y1 > y0) begin
        b.col    = CELL_W'(col_pos);
        b.row    = CELL_W'(row_pos);
        b.left   = IMG_W'(x0);
        b.top    = IMG_W'(y0);
        b.right  = IMG_W'(x1 - 1);
        b.bottom = IMG_W'(y1 - 1);
        b.score  = c.pooled;
        box_queue = {box_queue, b};
      end
    end
    // The wrap test is a compare against the current register value, so a
    // map size lowered below the counter, or a size of zero, wraps at once.
    if (col_pos + 1 >= map_cols) begin
      col_pos = 0;
      if (row_pos + 1 >= map_rows) row_pos = 0;
      else row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Rising edge: record the accepted cell transaction and check the accepted
  // box transaction. Inputs were driven at the falling edge, and the block's
  // outputs still hold their values from before this edge.
  always @(posedge clk) begin
    box_t got;
    box_t want;
    if (!rst && in_valid && !in_stall) begin
      predict_box(cur_cell);
      cells_accepted++;
      cell_taken = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      got = '{cell_col, cell_row, box_left, box_top, box_right, box_bottom, score};
      if (box_queue.size() == 0) begin
        failures++;
        if (mismatches < MAX_REPORTS)
          $display("Unexpected box: col %0d row %0d ltrb %0d %0d %0d %0d score %0d",
                   got.col, got.row, got.left, got.top, got.right, got.bottom, got.score);
        mismatches++;
      end else begin
        want = box_queue.pop_front();
        boxes_checked++;
        if (got.col != want.col || got.row != want.row || got.left != want.left ||
            got.top != want.top || got.right != want.right ||
            got.bottom != want.bottom || got.score != want.score) begin
          failures++;
          if (mismatches < MAX_REPORTS) begin
            $display("Box mismatch: expected col %0d row %0d ltrb %0d %0d %0d %0d score %0d",
                     want.col, want.row, want.left, want.top, want.right, want.bottom,
                     want.score);
            $display("              actual   col %0d row %0d ltrb %0d %0d %0d %0d score %0d",
                     got.col, got.row, got.left, got.top, got.right, got.bottom, got.score);
          end
          mismatches++;
        end
      end
      // The receiver draws how long it stalls before taking the next box.
      box_stall = draw_wait();
    end
  end

  // Cell driver. Once a transaction has gone through, it waits out the drawn
  // gap and then presents the next pending cell. in_valid gets exactly one
  // nonblocking assignment per edge so that back-to-back cells keep it high.
  always @(negedge clk) begin
    logic drive;
    drive = in_valid;
    if (rst) begin
      drive = 1'b0;
    end else begin
      if (cell_taken) begin
        cell_taken = 1'b0;
        cell_busy = 1'b0;
        drive = 1'b0;
      end
      if (!cell_busy) begin
        if (cell_gap > 0) begin
          cell_gap--;
        end else if (cell_queue.size() != 0) begin
          cur_cell = cell_queue.pop_front();
          heat        <= cur_cell.heat;
          pooled_heat <= cur_cell.pooled;
          offset_x    <= cur_cell.off_x;
          offset_y    <= cur_cell.off_y;
          dist_left   <= cur_cell.d_left;
          dist_top    <= cur_cell.d_top;
          dist_right  <= cur_cell.d_right;
          dist_bottom <= cur_cell.d_bottom;
          cell_busy = 1'b1;
          drive = 1'b1;
          cell_gap = draw_wait();
        end
      end
    end
    in_valid <= drive;
  end

  // Box receiver. The stall count runs down whether or not a box is waiting,
  // so stalls also land while the pipeline is filling.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (box_stall > 0) begin
      out_stall <= 1'b1;
      box_stall--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Writes one register through the configuration channel and mirrors the
  // masked value into the predictor once the transaction has gone through.
  task automatic write_reg(cpbd_pkg::cpbd_reg_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cpbd_pkg::REG_MAP_WIDTH:       map_cols   = data[CELL_W-1:0];
      cpbd_pkg::REG_MAP_HEIGHT:      map_rows   = data[CELL_W-1:0];
      cpbd_pkg::REG_SCORE_THRESHOLD: peak_floor = data[HEAT_W-1:0];
      cpbd_pkg::REG_IMAGE_WIDTH:     img_w      = data[IMG_W-1:0];
      cpbd_pkg::REG_IMAGE_HEIGHT:    img_h      = data[IMG_W-1:0];
      cpbd_pkg::REG_NET_WIDTH:       net_w      = data[NET_W-1:0];
      cpbd_pkg::REG_NET_HEIGHT:      net_h      = data[NET_W-1:0];
      cpbd_pkg::REG_INVERSE_SCALE:   inv_scale  = data[INV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Half of the time the bits above a register's width carry noise, which
  // the block must drop.
  function automatic logic [CFG_W-1:0] with_noise(longint value, int width);
    logic [CFG_W-1:0] data;
    data = CFG_W'(value);
    if ($urandom_range(0, 1) == 1) data = data | CFG_W'($urandom() << width);
    return data;
  endfunction

  task automatic write_settings(longint mw, longint mh, longint thr, longint iw,
                                longint ih, longint nw, longint nh, longint inv);
    write_reg(cpbd_pkg::REG_MAP_WIDTH,       with_noise(mw, CELL_W));
    write_reg(cpbd_pkg::REG_MAP_HEIGHT,      with_noise(mh, CELL_W));
    write_reg(cpbd_pkg::REG_SCORE_THRESHOLD, with_noise(thr, HEAT_W));
    write_reg(cpbd_pkg::REG_IMAGE_WIDTH,     with_noise(iw, IMG_W));
    write_reg(cpbd_pkg::REG_IMAGE_HEIGHT,    with_noise(ih, IMG_W));
    write_reg(cpbd_pkg::REG_NET_WIDTH,       with_noise(nw, NET_W));
    write_reg(cpbd_pkg::REG_NET_HEIGHT,      with_noise(nh, NET_W));
    write_reg(cpbd_pkg::REG_INVERSE_SCALE,   CFG_W'(inv));
    settings_count++;
  endtask

  task automatic queue_cell(int h, int p, int ox, int oy, int dl, int dt, int dr, int db);
    cell_t c;
    c = '{HEAT_W'(h), HEAT_W'(p), FIX_W'(ox), FIX_W'(oy),
          FIX_W'(dl), FIX_W'(dt), FIX_W'(dr), FIX_W'(db)};
    cell_queue = {cell_queue, c};
  endtask

  // Most random cells are peaks with plausible offsets and distances, so that
  // boxes land on the image; the rest are raw noise, near misses of the peak
  // test and cells at or below the threshold.
  task automatic queue_random_cell();
    cell_t c;
    int    kind;
    c = '{HEAT_W'($urandom()), HEAT_W'($urandom()), FIX_W'($urandom()), FIX_W'($urandom()),
          FIX_W'($urandom()), FIX_W'($urandom()), FIX_W'($urandom()), FIX_W'($urandom())};
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      c.pooled   = (peak_floor >= 65535) ? 16'hFFFF
                                         : HEAT_W'($urandom_range(int'(peak_floor) + 1, 65535));
      c.heat     = c.pooled;
      c.off_x    = FIX_W'($urandom_range(0, 255));
      c.off_y    = FIX_W'($urandom_range(0, 255));
      c.d_left   = FIX_W'($urandom_range(0, 8192));
      c.d_top    = FIX_W'($urandom_range(0, 8192));
      c.d_right  = FIX_W'($urandom_range(0, 8192));
      c.d_bottom = FIX_W'($urandom_range(0, 8192));
    end else if (kind < 70) begin
      c.heat = c.pooled;
    end else if (kind < 85) begin
      c.heat = c.pooled + HEAT_W'($urandom_range(1, 65535));
    end else begin
      c.pooled = HEAT_W'($urandom_range(0, int'(peak_floor)));
      c.heat = c.pooled;
    end
    cell_queue = {cell_queue, c};
  endtask

  // Waits until every cell has gone in and every expected box has come out,
  // then lets the pipeline drain of cells that produce nothing. Boxes that
  // never arrive within the bound are reported and dropped.
  task automatic settle();
    int waited;
    while (cell_queue.size() != 0 || cell_busy) @(negedge clk);
    waited = 0;
    while (box_queue.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (box_queue.size() != 0) begin
      $display("Missing boxes: %0d expected boxes never arrived", box_queue.size());
      failures += box_queue.size();
      box_queue.delete();
    end
  endtask

  // Run sequence: reset, a directed phase under the reset settings, a short
  // directed phase on a tiny map for the counter wrap, then random phases.
  initial begin
    longint mw;
    longint mh;
    longint thr;
    longint iw;
    longint ih;
    longint nw;
    longint nh;
    longint inv;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Under the reset settings a cell at column zero maps to the left image
    // edge, so small offsets give boxes that touch the border.
    queue_cell(40000, 40000, 128, 128, 512, 512, 512, 512);
    // Pooled heat equal to the threshold is not a peak; one above is.
    queue_cell(26214, 26214, 0, 0, 512, 512, 512, 512);
    queue_cell(26215, 26215, 0, 0, 512, 512, 512, 512);
    // Heat below or above the pooled heat is not a peak.
    queue_cell(39999, 40000, 0, 0, 512, 512, 512, 512);
    queue_cell(40001, 40000, 0, 0, 512, 512, 512, 512);
    queue_cell(0, 0, 0, 0, 512, 512, 512, 512);
    // Largest and smallest offsets and distances; the second turns inside out.
    queue_cell(65535, 65535, 262143, 262143, 262143, 262143, 262143, 262143);
    queue_cell(65535, 65535, -262144, -262144, -262144, -262144, -262144, -262144);
    // Negative distances swap the edges.
    queue_cell(50000, 50000, 2560, 2560, -1024, -1024, -1024, -1024);
    // Boxes entirely left of and below the image are dropped after clipping.
    queue_cell(50000, 50000, -51200, 0, 256, 256, 256, 256);
    queue_cell(50000, 50000, 0, 262143, 256, 256, 256, 256);
    // Zero distances give a box of a single pixel.
    queue_cell(50000, 50000, 0, 0, 0, 0, 0, 0);
    settle();

    // The column is past three here, so lowering the map width wraps the
    // counter on the next cell; seven more cells then walk the 3 by 2 map past a row wrap.
    write_reg(cpbd_pkg::REG_MAP_WIDTH, CFG_W'(3));
    write_reg(cpbd_pkg::REG_MAP_HEIGHT, CFG_W'(2));
    write_reg(cpbd_pkg::REG_SCORE_THRESHOLD, CFG_W'(0));
    queue_cell(0, 0, 0, 0, 0, 0, 0, 0);
    repeat (7) queue_cell(1, 1, 128, 128, 0, 0, 256, 256);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      mw  = $urandom_range(1, 12);
      mh  = $urandom_range(1, 6);
      thr = $urandom_range(0, 60000);
      iw  = $urandom_range(64, 8191);
      ih  = $urandom_range(64, 8191);
      inv = $urandom_range(32768, 196608);
      case (phase)
        0: begin
          // Smallest map and image sizes and scale with a zero threshold.
          mw = 1; mh = 1; thr = 0; iw = 1; ih = 1; inv = 1;
        end
        1: begin
          // Largest map and image sizes and scale; only the top heat value is a peak.
          mw = 1023; mh = 1023; thr = 65534; iw = 8191; ih = 8191; inv = 16777215;
        end
        2: begin
          // Map sizes of zero (written as 1024, which masks to zero), the
          // widest network and the smallest scale.
          mw = 1024; mh = 1024; inv = 1;
        end
        default: ;
      endcase
      // Keep the network size consistent with the image so that boxes near
      // the first cells fall inside the image.
      nw = (iw * 65536) / inv;
      nh = (ih * 65536) / inv;
      if (phase == 2) begin
        nw = 4095;
        nh = 4095;
      end
      if (nw < 1) nw = 1;
      if (nw > 4095) nw = 4095;
      if (nh < 1) nh = 1;
      if (nh > 4095) nh = 4095;
      write_settings(mw, mh, thr, iw, ih, nw, nh, inv);
      idle_on = (phase != 3) && ($urandom_range(0, 3) != 0);
      repeat (56) queue_random_cell();
      settle();
    end

    $display("Run covered %0d cells and %0d boxes under %0d register settings.",
             cells_accepted, boxes_checked, settings_count + 2);
    $display("Mismatching or missing boxes: %0d.", failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d cells pending and %0d boxes outstanding.",
             cell_queue.size(), box_queue.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
